// ----- design/ssd_pkg.sv -----
// Shared types, constants and glyph helpers for the seven-segment scan dimmer.
package ssd_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int GLYPH_W    = 8;
    localparam int POS_W      = 3;
    localparam int DIM_W      = 5;
    localparam int THR_W      = 7;
    localparam int LIGHT_W    = 10;
    localparam int BIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [GLYPH_W-1:0] DOT_BIT       = 8'h80;
    localparam logic [THR_W-1:0]   THR_DEFAULT   = 7'd50;
    localparam logic [THR_W-1:0]   THR_MAX       = 7'd99;
    localparam logic [DIM_W-1:0]   DIM_MAX       = 5'd16;
    localparam logic [DIM_W-1:0]   DIM_RESET     = 5'd0;
    localparam logic [GLYPH_W-1:0] STROBE_FIRST  = 8'h80;

    // Item kinds carried on tuser
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_UPDATE = 1'b1
    } ssd_op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_THRESHOLD = 2'd0,
        CFG_DIM_SETTING     = 2'd1
    } ssd_cfg_idx_t;

    // Everything an update request writes into the scan state
    typedef struct packed {
        logic [NUM_DIGITS-1:0][GLYPH_W-1:0] glyph;
        logic                               skip_we;
        logic [DIM_W-1:0]                   skip;
    } ssd_upd_t;

    // Digit to segment pattern, segments a..g in bits 0..6
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [3:0] d);
        logic [GLYPH_W-1:0] g;
        unique case (d)
            4'd0:    g = 8'd63;
            4'd1:    g = 8'd6;
            4'd2:    g = 8'd91;
            4'd3:    g = 8'd79;
            4'd4:    g = 8'd102;
            4'd5:    g = 8'd109;
            4'd6:    g = 8'd125;
            4'd7:    g = 8'd7;
            4'd8:    g = 8'd127;
            default: g = 8'd111;
        endcase
        return g;
    endfunction

    // One-hot strobe, digit 0 on the top bit
    function automatic logic [GLYPH_W-1:0] strobe_of(input logic [POS_W-1:0] pos);
        return STROBE_FIRST >> pos;
    endfunction

endpackage

// ----- design/ssd_glyph_enc.sv -----
// Update decode: BCD time to six glyphs, ambient light to frame skip depth.
module ssd_glyph_enc
    import ssd_pkg::*;
(
    input  logic [7:0]         seconds_bcd,
    input  logic [7:0]         minutes_bcd,
    input  logic [7:0]         hours_bcd,
    input  logic [LIGHT_W-1:0] light_sample,
    input  logic [THR_W-1:0]   light_threshold,
    input  logic [DIM_W-1:0]   dim_setting,
    output ssd_upd_t           upd
);

    logic [BIN_W-1:0]   sec_bin, min_bin, hr_bin;
    logic [3:0]         sec_tens, sec_ones, min_tens, min_ones, hr_tens, hr_ones;
    logic [THR_W-1:0]   thr_eff;
    logic [DIM_W-1:0]   dim_eff;
    logic [LIGHT_W:0]   light_limit;
    logic               bright;

    // BCD to binary: low nibble plus ten times the masked high nibble
    function automatic logic [BIN_W-1:0] bcd_bin(input logic [3:0] lo, input logic [2:0] hi);
        return BIN_W'(lo) + BIN_W'(hi) * BIN_W'(10);
    endfunction

    // Split into tens and ones; times 205 then >> 11 is exact below 1024
    function automatic logic [3:0] tens_of(input logic [BIN_W-1:0] v);
        logic [BIN_W+8:0] prod;
        prod = (BIN_W+9)'(v) * (BIN_W+9)'(205);
        return prod[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [BIN_W-1:0] v, input logic [3:0] t);
        logic [BIN_W-1:0] r;
        r = v - BIN_W'(t) * BIN_W'(10);
        return r[3:0];
    endfunction

    assign sec_bin  = bcd_bin(seconds_bcd[3:0], seconds_bcd[6:4]);
    assign min_bin  = bcd_bin(minutes_bcd[3:0], minutes_bcd[6:4]);
    assign hr_bin   = bcd_bin(hours_bcd[3:0], {1'b0, hours_bcd[5:4]});

    assign sec_tens = tens_of(sec_bin);
    assign min_tens = tens_of(min_bin);
    assign hr_tens  = tens_of(hr_bin);
    assign sec_ones = ones_of(sec_bin, sec_tens);
    assign min_ones = ones_of(min_bin, min_tens);
    assign hr_ones  = ones_of(hr_bin, hr_tens);

    // Glyphs, dots after hours and minutes
    assign upd.glyph[5] = glyph_of(sec_ones);
    assign upd.glyph[4] = glyph_of(sec_tens);
    assign upd.glyph[3] = glyph_of(min_ones) | DOT_BIT;
    assign upd.glyph[2] = glyph_of(min_tens);
    assign upd.glyph[1] = glyph_of(hr_ones) | DOT_BIT;
    assign upd.glyph[0] = glyph_of(hr_tens);

    // Out-of-range settings fall back to defaults / saturate
    assign thr_eff = (light_threshold == '0 || light_threshold > THR_MAX) ?
                     THR_DEFAULT : light_threshold;
    assign dim_eff = (dim_setting > DIM_MAX) ? DIM_MAX : dim_setting;

    // light/10 > thr  <=>  light >= 10*(thr+1)
    assign light_limit = (LIGHT_W+1)'(thr_eff) * (LIGHT_W+1)'(10) + (LIGHT_W+1)'(10);
    assign bright      = {1'b0, light_sample} >= light_limit;

    // Even seconds value iff the low BCD bit is clear
    assign upd.skip_we = ~seconds_bcd[0];
    assign upd.skip    = bright ? '0 : dim_eff;

endmodule

// ----- design/ssd_scan.sv -----
// Scan state: glyph store, digit position, dim counter and the result register.
module ssd_scan
    import ssd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  ssd_op_t             in_op,
    input  ssd_upd_t            upd,
    output logic                advance,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [GLYPH_W-1:0]  digit_drive,
    output logic [GLYPH_W-1:0]  segment_drive
);

    logic [NUM_DIGITS-1:0][GLYPH_W-1:0] glyph_reg;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_eff;
    logic [DIM_W-1:0]   dim_reg, dim_next, dim_inc;
    logic [DIM_W-1:0]   skip_reg;
    logic               out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0] digit_reg, seg_reg;
    logic               is_tick, last_digit;

    // An update never waits; a tick needs room in the result register
    assign is_tick = (in_op == OP_TICK);
    assign advance = in_valid && (!is_tick || !out_valid_reg || m_tready);

    assign pos_eff    = (pos_reg >= POS_W'(NUM_DIGITS)) ? '0 : pos_reg;
    assign last_digit = (pos_eff == POS_W'(NUM_DIGITS - 1));
    assign dim_inc    = dim_reg + DIM_W'(1);

    // Position advances per tick; the dim counter advances when the position wraps
    always_comb begin
        pos_next = pos_reg;
        dim_next = dim_reg;
        if (advance && is_tick) begin
            if (last_digit) begin
                pos_next = '0;
                dim_next = (dim_inc > skip_reg) ? '0 : dim_inc;
            end else begin
                pos_next = pos_eff + POS_W'(1);
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && is_tick)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            dim_reg       <= '0;
            skip_reg      <= '0;
            glyph_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            dim_reg       <= dim_next;
            out_valid_reg <= out_valid_next;
            if (advance && !is_tick) begin
                glyph_reg <= upd.glyph;
                if (upd.skip_we)
                    skip_reg <= upd.skip;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance && is_tick) begin
            digit_reg <= strobe_of(pos_eff);
            seg_reg   <= (dim_reg == '0) ? glyph_reg[pos_eff] : '0;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign digit_drive   = digit_reg;
    assign segment_drive = seg_reg;

endmodule

// ----- design/seven_segment_clock_scan_dimmer_core.sv -----
// Path: an accepted request is registered at the input; a tick then loads the result register.
// Throughput: one request per clock unless a tick waits on a stalled result; the input
//   and result registers decouple both sides, and an update request produces no result.
// Reset: synchronous, active low aresetn clears scan position, dim counter, frame skip,
//   glyph store, valid flags and sets configuration to its defaults.
// Top level: input register, configuration registers, update decode and scan state.
module seven_segment_clock_scan_dimmer_core
    import ssd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,  // seconds_bcd, minutes_bcd, hours_bcd, light_sample, pad
    input  logic                  s_tuser,  // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,  // digit_drive, segment_drive
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               in_valid_reg;
    ssd_op_t            in_op_reg;
    logic [7:0]         sec_reg, min_reg, hr_reg;
    logic [LIGHT_W-1:0] light_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [DIM_W-1:0]   dim_set_reg;
    logic               advance;
    ssd_upd_t           upd;
    logic [GLYPH_W-1:0] digit_drive, segment_drive;

    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg <= ssd_op_t'(s_tuser);
            sec_reg   <= s_tdata[7:0];
            min_reg   <= s_tdata[15:8];
            hr_reg    <= s_tdata[23:16];
            light_reg <= s_tdata[33:24];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THR_DEFAULT;
            dim_set_reg <= DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_LIGHT_THRESHOLD)
                thr_reg <= cfg_data[THR_W-1:0];
            else if (cfg_index == CFG_DIM_SETTING)
                dim_set_reg <= cfg_data[DIM_W-1:0];
        end
    end

    ssd_glyph_enc u_enc (
        .seconds_bcd     (sec_reg),
        .minutes_bcd     (min_reg),
        .hours_bcd       (hr_reg),
        .light_sample    (light_reg),
        .light_threshold (thr_reg),
        .dim_setting     (dim_set_reg),
        .upd             (upd)
    );

    ssd_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_valid_reg),
        .in_op         (in_op_reg),
        .upd           (upd),
        .advance       (advance),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .digit_drive   (digit_drive),
        .segment_drive (segment_drive)
    );

    assign m_tdata = {segment_drive, digit_drive};

endmodule

// ----- design/ssd_checker.sv -----
// Port-level checks on the result channel of the scan dimmer core.
module ssd_checker
    import ssd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result holds its valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result holds its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // Strobe is one-hot within the six digit bits
    a_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[7:0]) && (m_tdata[1:0] == 2'b00))
        else $error("digit strobe not one-hot on a digit position");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind seven_segment_clock_scan_dimmer_core ssd_checker u_ssd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
